// File: rtl/core/frame_header_validator_unit_macros.svh
// assertion helpers for the frame header validator
`ifndef FRAME_HEADER_VALIDATOR_UNIT_MACROS_SVH
`define FRAME_HEADER_VALIDATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FHV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame header validator check failed");

// next-cycle implication
`define FHV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame header validator check failed");

`endif

// File: rtl/core/fhv_pkg.sv
`timescale 1ns / 1ps
package fhv_pkg;

  localparam int HDR_BYTES = 48;
  localparam int HDR_BITS  = HDR_BYTES * 8;
  localparam int POS_W     = 6;

  // byte offsets of the header fields
  localparam int OFS_MAGIC   = 0;
  localparam int OFS_VERSION = 4;
  localparam int OFS_HSIZE   = 6;
  localparam int OFS_SEQ     = 8;
  localparam int OFS_TIME    = 16;
  localparam int OFS_WIDTH   = 24;
  localparam int OFS_HEIGHT  = 28;
  localparam int OFS_STRIDE  = 32;
  localparam int OFS_FORMAT  = 36;
  localparam int OFS_PAYLOAD = 40;

  // magic bytes as a little-endian word
  localparam logic [31:0] MAGIC_WORD = {8'h46, 8'h4B, 8'h56, 8'h4C};

  typedef logic [3:0] status_t;
  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_NEED_MORE = 4'd1;
  localparam status_t ST_MAGIC     = 4'd2;
  localparam status_t ST_VERSION   = 4'd3;
  localparam status_t ST_HSIZE     = 4'd4;
  localparam status_t ST_FORMAT    = 4'd5;
  localparam status_t ST_DIMENSION = 4'd6;
  localparam status_t ST_STRIDE    = 4'd7;
  localparam status_t ST_LENGTH    = 4'd8;
  localparam status_t ST_TOO_LARGE = 4'd9;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VERSION     = 3'd0;
  localparam cfg_idx_t CFG_FORMAT      = 3'd1;
  localparam cfg_idx_t CFG_MIN_WIDTH   = 3'd2;
  localparam cfg_idx_t CFG_MAX_WIDTH   = 3'd3;
  localparam cfg_idx_t CFG_MIN_HEIGHT  = 3'd4;
  localparam cfg_idx_t CFG_MAX_HEIGHT  = 3'd5;
  localparam cfg_idx_t CFG_MAX_PAYLOAD = 3'd6;

  typedef struct packed {
    logic shift;
    logic mult;
    logic check;
    logic load_short;
  } dp_cmd_t;

endpackage

// File: rtl/core/fhv_ctrl.sv
`timescale 1ns / 1ps
module fhv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            end_of_buffer,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  output fhv_pkg::dp_cmd_t cmd
);
  import fhv_pkg::*;

  typedef enum logic [2:0] {S_COLLECT, S_DRAIN, S_MULT, S_CHECK, S_OUT} state_t;

  state_t           state;
  logic [POS_W-1:0] pos;
  logic             rearm_after;
  logic             in_beat;
  logic             last_byte;

  assign in_stall  = !(state == S_COLLECT || state == S_DRAIN);
  assign in_beat   = in_valid && !in_stall;
  assign last_byte = (pos == POS_W'(HDR_BYTES - 1));

  always_comb begin
    cmd            = '0;
    cmd.shift      = in_beat && state == S_COLLECT;
    cmd.load_short = in_beat && state == S_COLLECT && !last_byte && end_of_buffer;
    cmd.mult       = (state == S_MULT);
    cmd.check      = (state == S_CHECK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_COLLECT;
      pos         <= '0;
      rearm_after <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_COLLECT: begin
          if (in_beat) begin
            priority if (last_byte) begin
              pos         <= '0;
              rearm_after <= end_of_buffer;
              state       <= S_MULT;
            end else if (end_of_buffer) begin
              pos         <= '0;
              rearm_after <= 1'b1;
              out_valid   <= 1'b1;
              state       <= S_OUT;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          if (in_beat && end_of_buffer) state <= S_COLLECT;
        end
        S_MULT: state <= S_CHECK;
        S_CHECK: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= rearm_after ? S_COLLECT : S_DRAIN;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

endmodule

// File: rtl/core/fhv_datapath.sv
`timescale 1ns / 1ps
module fhv_datapath (
  input  logic             clk,
  input  logic             rst,
  input  fhv_pkg::dp_cmd_t cmd,
  input  logic [7:0]       data_byte,
  input  logic             cfg_we,
  input  fhv_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]      cfg_data,
  output fhv_pkg::status_t status,
  output logic [63:0]      sequence_number,
  output logic signed [63:0] timestamp_ms,
  output logic [31:0]      frame_width,
  output logic [31:0]      frame_height,
  output logic [31:0]      row_stride,
  output logic [31:0]      pixel_format,
  output logic [63:0]      payload_length
);
  import fhv_pkg::*;

  logic [15:0] expected_version;
  logic [31:0] accepted_format;
  logic [31:0] min_width;
  logic [31:0] max_width;
  logic [31:0] min_height;
  logic [31:0] max_height;
  logic [63:0] max_payload;

  logic [HDR_BITS-1:0] hdr;
  logic [63:0]         prod;
  status_t             pre_status;

  logic [31:0] f_magic;
  logic [15:0] f_version;
  logic [15:0] f_hsize;
  logic [63:0] f_seq;
  logic [63:0] f_time;
  logic [31:0] f_width;
  logic [31:0] f_height;
  logic [31:0] f_stride;
  logic [31:0] f_format;
  logic [63:0] f_payload;
  logic [33:0] stride_exp;
  logic [63:0] payload_exp;
  status_t     pre_next;
  status_t     final_status;

  assign f_magic   = hdr[OFS_MAGIC*8   +: 32];
  assign f_version = hdr[OFS_VERSION*8 +: 16];
  assign f_hsize   = hdr[OFS_HSIZE*8   +: 16];
  assign f_seq     = hdr[OFS_SEQ*8     +: 64];
  assign f_time    = hdr[OFS_TIME*8    +: 64];
  assign f_width   = hdr[OFS_WIDTH*8   +: 32];
  assign f_height  = hdr[OFS_HEIGHT*8  +: 32];
  assign f_stride  = hdr[OFS_STRIDE*8  +: 32];
  assign f_format  = hdr[OFS_FORMAT*8  +: 32];
  assign f_payload = hdr[OFS_PAYLOAD*8 +: 64];

  assign stride_exp  = {2'b00, f_width} + {1'b0, f_width, 1'b0};
  // width * height * 3 with 64-bit wrap
  assign payload_exp = prod + {prod[62:0], 1'b0};

  always_comb begin
    priority if (f_magic != MAGIC_WORD)          pre_next = ST_MAGIC;
    else if (f_version != expected_version)       pre_next = ST_VERSION;
    else if (f_hsize != 16'(HDR_BYTES))           pre_next = ST_HSIZE;
    else if (f_format != accepted_format)         pre_next = ST_FORMAT;
    else if (f_width < min_width || f_width > max_width ||
             f_height < min_height || f_height > max_height)
                                                  pre_next = ST_DIMENSION;
    else if ({2'b00, f_stride} != stride_exp)     pre_next = ST_STRIDE;
    else                                          pre_next = ST_OK;
  end

  always_comb begin
    priority if (pre_status != ST_OK)  final_status = pre_status;
    else if (f_payload != payload_exp) final_status = ST_LENGTH;
    else if (f_payload > max_payload)  final_status = ST_TOO_LARGE;
    else                               final_status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 16'd1;
      accepted_format  <= 32'd1;
      min_width        <= 32'd1;
      max_width        <= 32'd4096;
      min_height       <= 32'd1;
      max_height       <= 32'd4096;
      max_payload      <= 64'd50331648;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERSION:     expected_version <= cfg_data[15:0];
        CFG_FORMAT:      accepted_format  <= cfg_data[31:0];
        CFG_MIN_WIDTH:   min_width        <= cfg_data[31:0];
        CFG_MAX_WIDTH:   max_width        <= cfg_data[31:0];
        CFG_MIN_HEIGHT:  min_height       <= cfg_data[31:0];
        CFG_MAX_HEIGHT:  max_height       <= cfg_data[31:0];
        CFG_MAX_PAYLOAD: max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  // header bytes shift in from the top, byte 0 lands at the bottom
  always_ff @(posedge clk) begin
    if (cmd.shift) hdr <= {data_byte, hdr[HDR_BITS-1:8]};
    if (cmd.mult) begin
      prod       <= 64'(f_width) * 64'(f_height);
      pre_status <= pre_next;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.check) begin
      status <= final_status;
      if (final_status == ST_OK) begin
        sequence_number <= f_seq;
        timestamp_ms    <= f_time;
        frame_width     <= f_width;
        frame_height    <= f_height;
        row_stride      <= f_stride;
        pixel_format    <= f_format;
        payload_length  <= f_payload;
      end else begin
        sequence_number <= '0;
        timestamp_ms    <= '0;
        frame_width     <= '0;
        frame_height    <= '0;
        row_stride      <= '0;
        pixel_format    <= '0;
        payload_length  <= '0;
      end
    end else if (cmd.load_short) begin
      status          <= ST_NEED_MORE;
      sequence_number <= '0;
      timestamp_ms    <= '0;
      frame_width     <= '0;
      frame_height    <= '0;
      row_stride      <= '0;
      pixel_format    <= '0;
      payload_length  <= '0;
    end
  end

endmodule

// File: rtl/core/frame_header_validator_unit.sv
`timescale 1ns / 1ps
// Frame header validator: header bytes are taken one beat per cycle while the block
// collects; after the 48th byte the input stalls through a multiply state for the
// width times height product and a check state for the final payload compare, and
// then until the result beat is taken. A buffer that ends early gives its need-more
// result in the cycle after its last byte. Bytes that follow a finished header are
// swallowed one per cycle with no result until the end marker. Configuration writes
// are always ready and take effect at once.
module frame_header_validator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_buffer,
  output logic               out_valid,
  input  logic               out_stall,
  output fhv_pkg::status_t   status,
  output logic [63:0]        sequence_number,
  output logic signed [63:0] timestamp_ms,
  output logic [31:0]        frame_width,
  output logic [31:0]        frame_height,
  output logic [31:0]        row_stride,
  output logic [31:0]        pixel_format,
  output logic [63:0]        payload_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  fhv_pkg::cfg_idx_t  cfg_index,
  input  logic [63:0]        cfg_data
);
  import fhv_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  fhv_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .end_of_buffer (end_of_buffer),
    .in_stall      (in_stall),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  fhv_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .data_byte       (data_byte),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .status          (status),
    .sequence_number (sequence_number),
    .timestamp_ms    (timestamp_ms),
    .frame_width     (frame_width),
    .frame_height    (frame_height),
    .row_stride      (row_stride),
    .pixel_format    (pixel_format),
    .payload_length  (payload_length)
  );

endmodule

// File: rtl/core/fhv_checker.sv
`timescale 1ns / 1ps
`include "frame_header_validator_unit_macros.svh"
module fhv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input fhv_pkg::status_t   status,
  input logic [63:0]        sequence_number,
  input logic [31:0]        frame_width,
  input logic [63:0]        payload_length
);
  import fhv_pkg::*;

  // no byte is taken while a result waits
  `FHV_ASSERT_NOW(a_stall_while_result, out_valid, in_stall)
  // a taken result is never followed at once by another
  `FHV_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid)
  // fields are cleared on any failing status
  `FHV_ASSERT_NOW(a_zero_on_error, out_valid && status != ST_OK,
                  sequence_number == 64'd0 && frame_width == 32'd0 &&
                  payload_length == 64'd0)
  `FHV_ASSERT_NOW(a_status_range, out_valid, status <= ST_TOO_LARGE)
  `FHV_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(status))

endmodule

bind frame_header_validator_unit fhv_checker u_fhv_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import fhv_pkg::*;

  localparam cfg_idx_t CFG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_BYTES = 96;
  localparam int PHASE_BUFFERS = 2;

  typedef enum int {
    FLT_MAGIC, FLT_VERSION, FLT_HSIZE, FLT_FORMAT, FLT_WIDTH, FLT_HEIGHT,
    FLT_STRIDE, FLT_PAYLOAD, FLT_NOISE
  } fault_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } feed_beat_t;

  typedef struct {
    status_t            st;
    logic [63:0]        seq;
    logic signed [63:0] ts;
    logic [31:0]        width;
    logic [31:0]        height;
    logic [31:0]        stride;
    logic [31:0]        format;
    logic [63:0]        payload;
  } header_report_t;

  typedef struct {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] hsize;
    logic [63:0] seq;
    logic [63:0] ts;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] stride;
    logic [31:0] format;
    logic [63:0] payload;
  } header_fields_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               end_of_buffer = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            status;
  logic [63:0]        sequence_number;
  logic signed [63:0] timestamp_ms;
  logic [31:0]        frame_width;
  logic [31:0]        frame_height;
  logic [31:0]        row_stride;
  logic [31:0]        pixel_format;
  logic [63:0]        payload_length;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_VERSION;
  logic [63:0]        cfg_data = '0;

  frame_header_validator_unit uut (.*);

  always #10 clk = ~clk;

  // predictor copy of the limits
  logic [15:0] want_version = 16'd1;
  logic [31:0] want_format = 32'd1;
  logic [31:0] lo_width = 32'd1;
  logic [31:0] hi_width = 32'd4096;
  logic [31:0] lo_height = 32'd1;
  logic [31:0] hi_height = 32'd4096;
  logic [63:0] payload_cap = 64'd50331648;

  // predictor copy of the header collector
  logic [HDR_BITS-1:0] hdr_image = '0;
  int unsigned         hdr_fill = 0;
  bit                  hdr_closed = 1'b0;

  feed_beat_t     byte_feed[$];
  header_report_t header_reports[$];

  int unsigned fault_count = 0;
  int unsigned header_bytes_queued = 0;
  int unsigned buffers_queued = 0;
  int unsigned cycle_count = 0;

  function automatic bit absorb_header_byte(input logic [7:0] b, input logic last,
                                            output header_report_t rep);
    logic [31:0] w, h, s, fm;
    logic [63:0] pl, stride_need, payload_need;
    bit emit;
    emit = 1'b0;
    rep = '{default: '0};
    if (!hdr_closed) begin
      hdr_image[hdr_fill*8 +: 8] = b;
      hdr_fill++;
      if (hdr_fill == HDR_BYTES) begin
        hdr_closed = 1'b1;
        emit = 1'b1;
        w = hdr_image[OFS_WIDTH*8 +: 32];
        h = hdr_image[OFS_HEIGHT*8 +: 32];
        s = hdr_image[OFS_STRIDE*8 +: 32];
        fm = hdr_image[OFS_FORMAT*8 +: 32];
        pl = hdr_image[OFS_PAYLOAD*8 +: 64];
        stride_need = 64'(w) * 64'd3;
        payload_need = stride_need * 64'(h);
        if (hdr_image[OFS_MAGIC*8 +: 32] != MAGIC_WORD) rep.st = ST_MAGIC;
        else if (hdr_image[OFS_VERSION*8 +: 16] != want_version) rep.st = ST_VERSION;
        else if (hdr_image[OFS_HSIZE*8 +: 16] != 16'(HDR_BYTES)) rep.st = ST_HSIZE;
        else if (fm != want_format) rep.st = ST_FORMAT;
        else if (w < lo_width || w > hi_width || h < lo_height || h > hi_height)
          rep.st = ST_DIMENSION;
        else if (64'(s) != stride_need) rep.st = ST_STRIDE;
        else if (pl != payload_need) rep.st = ST_LENGTH;
        else if (pl > payload_cap) rep.st = ST_TOO_LARGE;
        else begin
          rep.st = ST_OK;
          rep.seq = hdr_image[OFS_SEQ*8 +: 64];
          rep.ts = hdr_image[OFS_TIME*8 +: 64];
          rep.width = w;
          rep.height = h;
          rep.stride = s;
          rep.format = fm;
          rep.payload = pl;
        end
      end else if (last) begin
        emit = 1'b1;
        rep.st = ST_NEED_MORE;
      end
    end
    if (last) begin
      hdr_image = '0;
      hdr_fill = 0;
      hdr_closed = 1'b0;
    end
    return emit;
  endfunction

  function automatic int unsigned draw_wait(bit rush);
    if (rush || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [31:0] pick_span(logic [31:0] lo, logic [31:0] hi);
    if (lo >= hi) return lo;
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return (hi - lo > 32'd3000) ? lo + $urandom_range(0, 3000) : $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [31:0] outside_span(logic [31:0] lo, logic [31:0] hi,
                                               logic [31:0] cur);
    if (lo != 0 && (hi == '1 || $urandom_range(0, 1) == 0)) return $urandom_range(0, lo - 1);
    if (hi != '1)
      return ($urandom_range(0, 1) == 0) ? hi + 32'd1 : $urandom_range(hi + 1, 32'hFFFF_FFFF);
    return cur;
  endfunction

  function automatic void seal_geometry(inout header_fields_t f);
    logic [63:0] row;
    row = 64'(f.width) * 64'd3;
    f.stride = row[31:0];
    f.payload = row * 64'(f.height);
  endfunction

  function automatic header_fields_t good_header();
    header_fields_t f;
    f.magic = MAGIC_WORD;
    f.version = want_version;
    f.hsize = 16'(HDR_BYTES);
    f.seq = {$urandom, $urandom};
    f.ts = {$urandom, $urandom};
    f.format = want_format;
    f.width = pick_span(lo_width, hi_width);
    f.height = pick_span(lo_height, hi_height);
    seal_geometry(f);
    return f;
  endfunction

  function automatic void spoil_header(inout header_fields_t f, input fault_t flt);
    case (flt)
      FLT_MAGIC: f.magic ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
      FLT_VERSION: f.version ^= 16'($urandom_range(1, 65535));
      FLT_HSIZE: f.hsize ^= 16'($urandom_range(1, 65535));
      FLT_FORMAT: f.format ^= 32'd1 << $urandom_range(0, 31);
      FLT_WIDTH: begin
        f.width = outside_span(lo_width, hi_width, f.width);
        seal_geometry(f);
      end
      FLT_HEIGHT: begin
        f.height = outside_span(lo_height, hi_height, f.height);
        seal_geometry(f);
      end
      FLT_STRIDE: f.stride ^= 32'd1 << $urandom_range(0, 31);
      FLT_PAYLOAD: f.payload ^= 64'd1 << $urandom_range(0, 63);
      FLT_NOISE: begin
        f.magic = $urandom;
        f.version = 16'($urandom);
        f.hsize = 16'($urandom);
        f.seq = {$urandom, $urandom};
        f.ts = {$urandom, $urandom};
        f.width = $urandom;
        f.height = $urandom;
        f.stride = $urandom;
        f.format = $urandom;
        f.payload = {$urandom, $urandom};
      end
      default: ;
    endcase
  endfunction

  // cut > 0 ends the buffer early, trail adds ignored bytes after the header
  task automatic queue_frame(header_fields_t f, int cut, int trail);
    logic [HDR_BITS-1:0] img;
    feed_beat_t b;
    int n;
    int i;
    img = '0;
    img[OFS_MAGIC*8 +: 32] = f.magic;
    img[OFS_VERSION*8 +: 16] = f.version;
    img[OFS_HSIZE*8 +: 16] = f.hsize;
    img[OFS_SEQ*8 +: 64] = f.seq;
    img[OFS_TIME*8 +: 64] = f.ts;
    img[OFS_WIDTH*8 +: 32] = f.width;
    img[OFS_HEIGHT*8 +: 32] = f.height;
    img[OFS_STRIDE*8 +: 32] = f.stride;
    img[OFS_FORMAT*8 +: 32] = f.format;
    img[OFS_PAYLOAD*8 +: 64] = f.payload;
    n = (cut > 0) ? cut : HDR_BYTES;
    for (i = 0; i < n; i++) begin
      b.data = img[i*8 +: 8];
      b.last = (i == n - 1) && (cut > 0 || trail == 0);
      byte_feed.push_back(b);
    end
    if (cut == 0) begin
      for (i = 0; i < trail; i++) begin
        b.data = 8'($urandom);
        b.last = (i == trail - 1);
        byte_feed.push_back(b);
      end
    end
    header_bytes_queued += n;
    buffers_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || header_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VERSION: want_version = val[15:0];
      CFG_FORMAT: want_format = val[31:0];
      CFG_MIN_WIDTH: lo_width = val[31:0];
      CFG_MAX_WIDTH: hi_width = val[31:0];
      CFG_MIN_HEIGHT: lo_height = val[31:0];
      CFG_MAX_HEIGHT: hi_height = val[31:0];
      CFG_MAX_PAYLOAD: payload_cap = val;
      default: ;
    endcase
  endtask

  // upper data bits carry junk to show the narrow registers drop them
  task automatic set_limits(logic [15:0] ver, logic [31:0] fmt, logic [31:0] wmin,
                            logic [31:0] wmax, logic [31:0] hmin, logic [31:0] hmax,
                            logic [63:0] cap);
    write_reg(CFG_VERSION, {$urandom, 16'($urandom), ver});
    write_reg(CFG_FORMAT, {$urandom, fmt});
    write_reg(CFG_MIN_WIDTH, {$urandom, wmin});
    write_reg(CFG_MAX_WIDTH, {$urandom, wmax});
    write_reg(CFG_MIN_HEIGHT, {$urandom, hmin});
    write_reg(CFG_MAX_HEIGHT, {$urandom, hmax});
    write_reg(CFG_MAX_PAYLOAD, cap);
    @(negedge clk);
  endtask

  task automatic run_random_phase();
    header_fields_t f;
    int unsigned bytes0;
    int unsigned bufs0;
    int k;
    bytes0 = header_bytes_queued;
    bufs0 = buffers_queued;
    while (header_bytes_queued - bytes0 < PHASE_BYTES || buffers_queued - bufs0 < PHASE_BUFFERS)
    begin
      f = good_header();
      k = $urandom_range(0, 9);
      if (k >= 4) spoil_header(f, fault_t'($urandom_range(0, 8)));
      if (k == 9) spoil_header(f, fault_t'($urandom_range(0, 7)));
      queue_frame(f, ($urandom_range(0, 7) == 0) ? $urandom_range(1, HDR_BYTES - 1) : 0,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    end
    wait_idle();
  endtask

  task automatic check_field(string tag, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, tag, want, got);
      fault_count++;
    end
  endtask

  int unsigned feed_gap = 0;
  int unsigned feed_beats = 0;
  bit          feed_rush = 1'b0;

  always @(posedge clk) begin : feed_driver
    header_report_t rep;
    feed_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (absorb_header_byte(data_byte, end_of_buffer, rep)) header_reports.push_back(rep);
        feed_beats++;
        if (feed_beats % 64 == 0) feed_rush = ($urandom_range(0, 3) == 0);
        feed_gap = draw_wait(feed_rush);
      end
      if (!in_valid || !in_stall) begin
        if (feed_gap != 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          nxt = byte_feed.pop_front();
          data_byte <= nxt.data;
          end_of_buffer <= nxt.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int unsigned sink_wait = 0;
  int unsigned sink_beats = 0;
  bit          sink_rush = 1'b0;

  always @(posedge clk) begin : report_checker
    header_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (header_reports.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual status %0d",
                   $time, status);
          fault_count++;
        end else begin
          want = header_reports.pop_front();
          check_field("status", 64'(want.st), 64'(status));
          check_field("sequence_number", want.seq, sequence_number);
          check_field("timestamp_ms", want.ts, timestamp_ms);
          check_field("frame_width", 64'(want.width), 64'(frame_width));
          check_field("frame_height", 64'(want.height), 64'(frame_height));
          check_field("row_stride", 64'(want.stride), 64'(row_stride));
          check_field("pixel_format", 64'(want.format), 64'(pixel_format));
          check_field("payload_length", want.payload, payload_length);
        end
        sink_beats++;
        if (sink_beats % 16 == 0) sink_rush = ($urandom_range(0, 3) == 0);
        sink_wait = draw_wait(sink_rush);
      end else if (sink_wait == 0 && !sink_rush && $urandom_range(0, 15) == 0) begin
        sink_wait = $urandom_range(1, 17);
      end
      if (sink_wait != 0) begin
        sink_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    header_fields_t f;
    int flt;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits: largest legal frame, smallest frame, each fault but noise, short and trailing buffers
    f = good_header();
    f.width = hi_width;
    f.height = hi_height;
    f.seq = '1;
    f.ts = 64'h8000_0000_0000_0000;
    seal_geometry(f);
    queue_frame(f, 0, 0);
    f = good_header();
    f.width = lo_width;
    f.height = lo_height;
    f.seq = '0;
    f.ts = '1;
    seal_geometry(f);
    queue_frame(f, 0, 0);
    for (flt = FLT_MAGIC; flt <= FLT_PAYLOAD; flt++) begin
      f = good_header();
      spoil_header(f, fault_t'(flt));
      queue_frame(f, 0, 0);
    end
    queue_frame(good_header(), 1, 0);
    queue_frame(good_header(), HDR_BYTES - 1, 0);
    queue_frame(good_header(), 0, 5);
    wait_idle();
    run_random_phase();

    // widest limits, zero sized frame
    set_limits(16'hFFFF, '1, '0, '1, '0, '1, '1);
    f = good_header();
    f.width = '0;
    f.height = '0;
    seal_geometry(f);
    queue_frame(f, 0, 0);
    run_random_phase();

    // fixed width, tight payload cap
    set_limits('0, '0, 32'd7, 32'd7, 32'd1, 32'd64, 64'd1000);
    f = good_header();
    f.height = 32'd64;
    seal_geometry(f);
    queue_frame(f, 0, 0);
    run_random_phase();

    set_limits(16'($urandom), $urandom, 32'($urandom_range(0, 40)),
               lo_width + $urandom_range(0, 3000), 32'($urandom_range(0, 40)),
               lo_height + $urandom_range(0, 3000), 64'($urandom_range(0, 30000000)));
    set_limits(want_version, want_format, lo_width, lo_width + $urandom_range(0, 3000),
               lo_height, lo_height + $urandom_range(0, 3000), payload_cap);
    run_random_phase();

    // zero payload cap with zero width only
    set_limits(16'($urandom), $urandom, '0, '0, '0, '1, '0);
    run_random_phase();

    // empty dimension windows, write to an unused index
    set_limits(16'd1, 32'd1, 32'd100, 32'd99, 32'd4096, 32'd1, '1);
    write_reg(CFG_SPARE, {$urandom, $urandom});
    @(negedge clk);
    run_random_phase();

    set_limits(16'd1, 32'd1, 32'd1, 32'd4096, 32'd1, 32'd4096, 64'd50331648);
    run_random_phase();

    if (fault_count == 0 && header_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
